FILE: src/flmrh_pkg.sv
// Package for the four-lane multiply-rotate hash: hash constants, controller
// states, multiply operations and the command/status structs.
// Depends on nothing; every design file of the block imports it, the checker does not.
`default_nettype none

package flmrh_pkg;

	localparam logic [63:0] PHI   = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_A = 64'h85EBCA77C2B2AE3D;
	localparam logic [63:0] MIX_B = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_C = 64'h94D049BB133111EB;

	localparam int ROT_ONE   = 11;
	localparam int ROT_TWO   = 19;
	localparam int ROT_THREE = 35;
	localparam int ROT_FOUR  = 47;

	localparam int FIN_SHIFT_A = 29;
	localparam int FIN_SHIFT_B = 31;
	localparam int FIN_SHIFT_C = 37;
	localparam int FIN_SHIFT_D = 41;

	localparam logic [1:0] LANE_ONE   = 2'd0;
	localparam logic [1:0] LANE_TWO   = 2'd1;
	localparam logic [1:0] LANE_THREE = 2'd2;
	localparam logic [1:0] LANE_FOUR  = 2'd3;

	// Steps of one 64 x 64 (low half) product on a shared 32 x 32 multiplier.
	localparam logic [1:0] PH_LOLO = 2'd0;
	localparam logic [1:0] PH_LOHI = 2'd1;
	localparam logic [1:0] PH_HILO = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BASE,
		S_L1,
		S_L2,
		S_L3,
		S_L4,
		S_ABSORB,
		S_FIN1,
		S_FIN2,
		S_FIN3,
		S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_BASE,
		OP_L1,
		OP_L2,
		OP_L3,
		OP_L4,
		OP_ABSORB,
		OP_FIN1,
		OP_FIN2,
		OP_FIN3
	} op_t;

	typedef struct packed {
		logic       accept;
		op_t        op;
		logic [1:0] phase;
		logic       emit;
	} dp_cmd_t;

	typedef struct packed {
		logic in_active;
		logic in_first;
		logic in_has_data;
		logic in_last;
		logic has_data;
		logic last;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: src/flmrh_mul.sv
// Sequenced 64 x 64 multiplier keeping the low 64 bits, built on one
// 32 x 32 multiplier over three steps. Uses flmrh_pkg for the step codes.
`default_nettype none

module flmrh_mul
	import flmrh_pkg::*;
(
	input  wire logic        clk,
	input  wire logic [1:0]  phase,
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	output logic      [63:0] product
);

	logic [31:0] x;
	logic [31:0] y;
	logic [63:0] p;
	logic [63:0] acc_q;

	always_comb begin
		x = (phase == PH_HILO) ? a[63:32] : a[31:0];
		y = (phase == PH_LOHI) ? b[63:32] : b[31:0];
		p = 64'(x) * 64'(y);
	end

	always_ff @(posedge clk) begin
		case (phase)
			PH_LOLO: begin
				acc_q <= p;
			end
			PH_LOHI: begin
				acc_q[63:32] <= acc_q[63:32] + p[31:0];
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Valid during the last step; the cross term lands in the upper half.
	assign product = {acc_q[63:32] + p[31:0], acc_q[31:0]};

endmodule

`default_nettype wire

FILE: src/flmrh_dp.sv
// Datapath of the hash: lanes, length bookkeeping, the shared multiplier,
// finalizer and output register. Uses flmrh_pkg and flmrh_mul.
`default_nettype none

module flmrh_dp
	import flmrh_pkg::*;
#(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	output dp_status_t       status,
	input  wire logic        first,
	input  wire logic        last,
	input  wire logic [63:0] seed,
	input  wire logic [31:0] message_length,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] hash_value,
	output logic             length_mismatch
);

	localparam int CNT_BITS = LENGTH_BITS + 1;

	function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
		logic [63:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[i*8 +: 8] = (4'(i) < cnt) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

	logic [63:0]            lane_one_q, lane_two_q, lane_three_q, lane_four_q;
	logic [LENGTH_BITS-1:0] decl_q;
	logic [CNT_BITS-1:0]    bytes_q;
	logic                   in_msg_q;
	logic [63:0]            seed_q;
	logic [63:0]            word_q;
	logic [1:0]             sel_q;
	logic                   has_data_q;
	logic                   last_q;
	logic [63:0]            base_q;
	logic [63:0]            h_q;
	logic [63:0]            hash_q;
	logic                   mismatch_q;
	logic                   out_valid_q;

	logic [3:0]             cnt;
	logic [63:0]            mlen_wide;
	logic [LENGTH_BITS-1:0] mlen_eff;
	logic [LENGTH_BITS-1:0] eff_decl;
	logic [CNT_BITS-1:0]    eff_bytes;
	logic [CNT_BITS-1:0]    block_end;
	logic                   in_block;
	logic [1:0]             sel;
	logic [63:0]            masked;
	logic [63:0]            rotated;
	logic [CNT_BITS:0]      sum;
	logic [CNT_BITS-1:0]    next_bytes;
	logic                   active;

	logic [63:0] lane_sel_val;
	logic [63:0] fold;
	logic [63:0] mul_a;
	logic [63:0] mul_b;
	logic [63:0] product;
	logic        mul_done;

	// Input side: clamp the count, pad the word and pick its lane.
	always_comb begin
		cnt       = (byte_count > 4'd8) ? 4'd8 : byte_count;
		mlen_wide = 64'(message_length);
		mlen_eff  = mlen_wide[LENGTH_BITS-1:0];
		eff_decl  = first ? mlen_eff : decl_q;
		eff_bytes = first ? '0 : bytes_q;
		block_end = {1'b0, eff_decl[LENGTH_BITS-1:5], 5'b0};
		in_block  = eff_bytes < block_end;
		sel       = in_block ? eff_bytes[4:3] : LANE_ONE;
		masked    = data_word & byte_mask(cnt);
		case (sel)
			LANE_ONE:   rotated = (masked << ROT_ONE) | (masked >> (64 - ROT_ONE));
			LANE_TWO:   rotated = (masked << ROT_TWO) | (masked >> (64 - ROT_TWO));
			LANE_THREE: rotated = (masked << ROT_THREE) | (masked >> (64 - ROT_THREE));
			default:    rotated = (masked << ROT_FOUR) | (masked >> (64 - ROT_FOUR));
		endcase
		sum        = {1'b0, eff_bytes} + (CNT_BITS + 1)'(cnt);
		next_bytes = sum[CNT_BITS] ? '1 : sum[CNT_BITS-1:0];
		active     = first | in_msg_q;
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		case (sel_q)
			LANE_ONE:   lane_sel_val = lane_one_q;
			LANE_TWO:   lane_sel_val = lane_two_q;
			LANE_THREE: lane_sel_val = lane_three_q;
			default:    lane_sel_val = lane_four_q;
		endcase
		fold = (lane_one_q ^ lane_two_q) ^ (lane_three_q ^ lane_four_q);
		case (cmd.op)
			OP_BASE: begin
				mul_a = 64'(decl_q);
				mul_b = PHI;
			end
			OP_L1: begin
				mul_a = base_q;
				mul_b = PHI;
			end
			OP_L2: begin
				mul_a = base_q;
				mul_b = MIX_A;
			end
			OP_L3: begin
				mul_a = base_q;
				mul_b = MIX_B;
			end
			OP_L4: begin
				mul_a = base_q;
				mul_b = MIX_C;
			end
			OP_ABSORB: begin
				mul_a = lane_sel_val ^ word_q;
				mul_b = PHI;
			end
			OP_FIN1: begin
				mul_a = fold ^ (fold >> FIN_SHIFT_A);
				mul_b = MIX_A;
			end
			OP_FIN2: begin
				mul_a = h_q ^ (h_q >> FIN_SHIFT_B);
				mul_b = MIX_B;
			end
			OP_FIN3: begin
				mul_a = h_q ^ (h_q >> FIN_SHIFT_C);
				mul_b = PHI;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_done = (cmd.phase == PH_HILO);
	end

	flmrh_mul u_mul (
		.clk     (clk),
		.phase   (cmd.phase),
		.a       (mul_a),
		.b       (mul_b),
		.product (product)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_one_q   <= '0;
			lane_two_q   <= '0;
			lane_three_q <= '0;
			lane_four_q  <= '0;
			decl_q       <= '0;
			bytes_q      <= '0;
			in_msg_q     <= 1'b0;
			has_data_q   <= 1'b0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept && active) begin
				decl_q     <= eff_decl;
				bytes_q    <= next_bytes;
				in_msg_q   <= !last;
				has_data_q <= (cnt != 4'd0);
				last_q     <= last;
			end
			if (mul_done) begin
				case (cmd.op)
					OP_L1: lane_one_q <= product;
					OP_L2: lane_two_q <= product;
					OP_L3: lane_three_q <= product;
					OP_L4: lane_four_q <= product;
					OP_ABSORB: begin
						case (sel_q)
							LANE_ONE:   lane_one_q <= product;
							LANE_TWO:   lane_two_q <= product;
							LANE_THREE: lane_three_q <= product;
							default:    lane_four_q <= product;
						endcase
					end
					default: begin
					end
				endcase
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers, no reset.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			seed_q <= seed;
			word_q <= rotated;
			sel_q  <= sel;
		end
		if (mul_done) begin
			case (cmd.op)
				OP_BASE: base_q <= seed_q ^ product;
				OP_FIN1, OP_FIN2, OP_FIN3: h_q <= product;
				default: begin
				end
			endcase
		end
		if (cmd.emit) begin
			hash_q     <= h_q ^ (h_q >> FIN_SHIFT_D);
			mismatch_q <= (bytes_q != {1'b0, decl_q});
		end
	end

	always_comb begin
		status.in_active   = active;
		status.in_first    = first;
		status.in_has_data = (cnt != 4'd0);
		status.in_last     = last;
		status.has_data    = has_data_q;
		status.last        = last_q;
		status.out_busy    = out_valid_q && out_stall;
	end

	assign out_valid       = out_valid_q;
	assign hash_value      = hash_q;
	assign length_mismatch = mismatch_q;

endmodule

`default_nettype wire

FILE: src/flmrh_ctrl.sv
// Controller of the hash: walks seeding, absorb and finalizer multiplies,
// three steps each, and the result hand-off. Uses flmrh_pkg.
`default_nettype none

module flmrh_ctrl
	import flmrh_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	state_t     state_q;
	state_t     state_next;
	logic [1:0] phase_q;
	logic       is_mul;
	logic       last_phase;

	assign last_phase = (phase_q == PH_HILO);

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && status.in_active) begin
					if (status.in_first) begin
						state_next = S_BASE;
					end else if (status.in_has_data) begin
						state_next = S_ABSORB;
					end else if (status.in_last) begin
						state_next = S_FIN1;
					end
				end
			end
			S_BASE: if (last_phase) state_next = S_L1;
			S_L1:   if (last_phase) state_next = S_L2;
			S_L2:   if (last_phase) state_next = S_L3;
			S_L3:   if (last_phase) state_next = S_L4;
			S_L4: begin
				if (last_phase) begin
					if (status.has_data) begin
						state_next = S_ABSORB;
					end else if (status.last) begin
						state_next = S_FIN1;
					end else begin
						state_next = S_IDLE;
					end
				end
			end
			S_ABSORB: begin
				if (last_phase) begin
					state_next = status.last ? S_FIN1 : S_IDLE;
				end
			end
			S_FIN1: if (last_phase) state_next = S_FIN2;
			S_FIN2: if (last_phase) state_next = S_FIN3;
			S_FIN3: if (last_phase) state_next = S_EMIT;
			S_EMIT: if (!status.out_busy) state_next = S_IDLE;
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		is_mul     = 1'b1;
		cmd.op     = OP_NONE;
		cmd.accept = 1'b0;
		cmd.emit   = 1'b0;
		cmd.phase  = phase_q;
		in_stall   = 1'b1;
		case (state_q)
			S_IDLE: begin
				is_mul     = 1'b0;
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			S_BASE:   cmd.op = OP_BASE;
			S_L1:     cmd.op = OP_L1;
			S_L2:     cmd.op = OP_L2;
			S_L3:     cmd.op = OP_L3;
			S_L4:     cmd.op = OP_L4;
			S_ABSORB: cmd.op = OP_ABSORB;
			S_FIN1:   cmd.op = OP_FIN1;
			S_FIN2:   cmd.op = OP_FIN2;
			S_FIN3:   cmd.op = OP_FIN3;
			S_EMIT: begin
				is_mul   = 1'b0;
				cmd.emit = !status.out_busy;
			end
			default: is_mul = 1'b0;
		endcase
		if (!is_mul) begin
			cmd.phase = PH_LOLO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_LOLO;
		end else begin
			state_q <= state_next;
			if (is_mul && !last_phase) begin
				phase_q <= phase_q + 2'd1;
			end else begin
				phase_q <= PH_LOLO;
			end
		end
	end

endmodule

`default_nettype wire

FILE: src/four_lane_multiply_rotate_hash64_top.sv
// Top level of the four-lane multiply-rotate 64-bit hash.
// Depends on flmrh_pkg, flmrh_ctrl and flmrh_dp (which holds flmrh_mul).
//
//   Channel | Handshake          | Fields
//   --------+--------------------+----------------------------------------------
//   input   | in_valid, in_stall | first, last, seed, message_length,
//           |                    | data_word, byte_count
//   output  | out_valid,out_stall| hash_value, length_mismatch
//
// Every 64-bit product runs on one shared 32 x 32 multiplier, and that
// multiplier sets the timing. A word is taken while the block is idle; a word
// with bytes then adds its absorb multiply, a first word adds the five seeding
// multiplies, and a last word adds the finalizer multiplies and a load of the
// output register. A one-word message thus runs the seeding, absorb (if it
// has bytes) and finalizer multiplies, then loads the output register.
// Reset (arst_n low) is asynchronous and leaves the block idle with no message
// open. in_stall is high whenever a word is in work. A result waiting under
// out_stall does not block the next input word; only the hand-off of the
// following result waits until the output register is free.
`default_nettype none

module four_lane_multiply_rotate_hash64_top
	import flmrh_pkg::*;
#(
	parameter int LENGTH_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        first,
	input  wire logic        last,
	input  wire logic [63:0] seed,
	input  wire logic [31:0] message_length,
	input  wire logic [63:0] data_word,
	input  wire logic [3:0]  byte_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [63:0] hash_value,
	output logic             length_mismatch
);

	// The controller sequences the multiplies; the datapath holds the data state.
	dp_cmd_t    cmd;
	dp_status_t status;

	flmrh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	flmrh_dp #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.first           (first),
		.last            (last),
		.seed            (seed),
		.message_length  (message_length),
		.data_word       (data_word),
		.byte_count      (byte_count),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.hash_value      (hash_value),
		.length_mismatch (length_mismatch)
	);

endmodule

`default_nettype wire

FILE: src/flmrh_checker.sv
// Port-level checks for the hash top level, attached by a bind statement.
// Depends only on the ports of four_lane_multiply_rotate_hash64_top.
`default_nettype none

module flmrh_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        first,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] hash_value,
	input wire logic        length_mismatch
);

	// A held result stays valid.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	// A held result keeps its word.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(hash_value) && $stable(length_mismatch))
		else $error("result changed while stalled");

	// A new result is only loaded while the block is busy with a word.
	a_out_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work in progress");

	// A first word always starts the seeding multiplies.
	a_first_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && first |=> in_stall)
		else $error("first word accepted without seeding");

endmodule

bind four_lane_multiply_rotate_hash64_top flmrh_checker u_checker (.*);

`default_nettype wire
